### rtl/core/bmf3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmf3_pkg: shared types and constants of the 3x3 binary majority filter
// Opcodes, register indexes, reset values and the stage record that carries
// the per-pixel control decisions into the window datapath.
// ----------------------------------------------------------------------------
package bmf3_pkg;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    localparam int FRAME_WIDTH_BITS  = 13;
    localparam int FRAME_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS     = 16;

    // Fill and owed counters hold at most the lag.
    localparam int FILL_BITS = 14;

    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // Control record for one fed item, handed from the counter stage to the
    // window stage.
    typedef struct packed {
        logic emit;
        logic store;
        logic bottom;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
        logic frame_end;
    } t_stage;

endpackage
`default_nettype wire

### rtl/core/binary_majority_filter_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_majority_filter_3x3: 3x3 majority filter over a binary pixel stream
// Raster-order pixels pass through two line stores and a 3x3 window; each
// output is the majority of the in-frame neighbors, the center on a tie.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  ----------------------------
//  in       input      i_in_valid / o_in_stall     i_opcode, i_in_pixel
//  out      output     o_out_valid / i_out_stall   o_out_pixel, o_frame_end
//  cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One beat is taken per clock while o_in_stall is low. A beat crosses two
//  register stages: the first updates the raster counters and issues the
//  line store read, the second shifts the window and registers the result.
//  Outputs lag inputs by frame_width+1 pixels. Reset clears the counters, the
//  window and the valids; the line stores are not cleared. A stall on the
//  output holds the result register and, once the window stage holds an item
//  that has to emit, stalls the input.
//
module binary_majority_filter_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // pixel input
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_stall,
    input  wire logic                                  i_opcode,
    input  wire logic                                  i_in_pixel,
    // filtered output
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_stall,
    output      logic                                  o_out_pixel,
    output      logic                                  o_frame_end,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output      logic                                  o_cfg_ready,
    input  wire logic [0:0]                            i_cfg_index,
    input  wire logic [bmf3_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam int WB = bmf3_pkg::FRAME_WIDTH_BITS;
    localparam int HB = bmf3_pkg::FRAME_HEIGHT_BITS;
    localparam int FB = bmf3_pkg::FILL_BITS;

    // configuration
    logic [WB-1:0] r_frame_width;
    logic [HB-1:0] r_frame_height;
    logic [WB-1:0] eff_w;
    logic [HB-1:0] eff_h;

    // counter stage state
    logic [AW-1:0] r_in_col, n_in_col;
    logic [HB-1:0] r_in_row, n_in_row;
    logic [AW-1:0] r_out_col, n_out_col;
    logic [HB-1:0] r_out_row, n_out_row;
    logic [FB-1:0] r_fill, n_fill;
    logic [FB-1:0] r_owed, n_owed;

    // window stage inputs
    logic             r_s1_valid;
    bmf3_pkg::t_stage r_s1, n_s1;
    logic [AW-1:0]    r_s1_addr;
    logic             r_rd_up, r_rd_mid;
    logic             r_byp, r_byp_up, r_byp_mid;
    logic [8:0]       r_win, n_win;

    // result register
    logic r_out_valid, r_out_pixel, r_out_end;

    // line stores
    logic mem_up  [MAX_WIDTH];
    logic mem_mid [MAX_WIDTH];

    logic          acc_in, adv2, feed, wr_en, byp_hit;
    logic [AW-1:0] rd_addr;
    logic          top_eff, mid_eff;
    logic [3:0]    cnt_all, cnt_white;
    logic          res_pixel;
    logic [2:0]    col_ok, row_ok;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        eff_w = r_frame_width;
        if (r_frame_width == '0) begin
            eff_w = WB'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_w = WB'(MAX_WIDTH);
        end
        eff_h = (r_frame_height == '0) ? HB'(1) : r_frame_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bmf3_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= bmf3_pkg::FRAME_HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bmf3_pkg::t_cfg_index'(i_cfg_index))
                bmf3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WB-1:0];
                bmf3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HB-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign adv2       = r_s1_valid && (!r_s1.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv2;
    assign acc_in     = i_in_valid && !o_in_stall;
    assign wr_en      = adv2 && r_s1.store;

    // counter stage: every control decision of the item is made here
    always_comb begin
        logic [AW-1:0] c_in, c_out;
        logic [HB-1:0] r_out;
        logic          drained;
        c_in     = (CW'(r_in_col) < CW'(eff_w)) ? r_in_col : '0;
        c_out    = (CW'(r_out_col) < CW'(eff_w)) ? r_out_col : '0;
        r_out    = (r_out_row < eff_h) ? r_out_row : '0;
        rd_addr  = c_in;
        feed     = (bmf3_pkg::t_opcode'(i_opcode) == bmf3_pkg::OP_PIXEL) || (r_owed != '0);
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_fill   = r_fill;
        n_owed   = r_owed;
        drained  = 1'b0;

        n_s1.store     = (bmf3_pkg::t_opcode'(i_opcode) == bmf3_pkg::OP_PIXEL);
        n_s1.bottom    = n_s1.store && i_in_pixel;
        n_s1.emit      = feed && (r_fill > FB'(eff_w));
        n_s1.left_ok   = (c_out != '0);
        n_s1.right_ok  = (CW'(c_out) + CW'(1) < CW'(eff_w));
        n_s1.top_ok    = (r_out != '0);
        n_s1.bot_ok    = (CW'(r_out) + CW'(1) < CW'(eff_h));
        n_s1.frame_end = !n_s1.right_ok && !n_s1.bot_ok;

        if (feed) begin
            if (CW'(c_in) + CW'(1) >= CW'(eff_w)) begin
                n_in_col = '0;
                n_in_row = (CW'(r_in_row) + CW'(1) >= CW'(eff_h)) ? '0 : r_in_row + HB'(1);
            end else begin
                n_in_col = c_in + AW'(1);
            end
            if (n_s1.emit) begin
                if (n_s1.right_ok) begin
                    n_out_col = c_out + AW'(1);
                    n_out_row = r_out;
                end else begin
                    n_out_col = '0;
                    n_out_row = n_s1.bot_ok ? r_out + HB'(1) : '0;
                end
                if (!n_s1.store) begin
                    n_owed  = r_owed - FB'(1);
                    drained = (r_owed == FB'(1));
                end
            end else begin
                n_fill = r_fill + FB'(1);
                if (n_s1.store) begin
                    n_owed = r_owed + FB'(1);
                end
            end
            // Once the last owed pixel is out, the next pixel starts a fresh
            // lag at the next output position.
            if (drained) begin
                n_fill   = '0;
                n_in_col = n_out_col;
                n_in_row = n_out_row;
            end
        end
    end

    assign byp_hit = acc_in && feed && wr_en && (r_s1_addr == rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_fill     <= '0;
            r_owed     <= '0;
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (acc_in) begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_fill     <= n_fill;
            r_owed     <= n_owed;
            r_s1_valid <= feed;
            r_byp      <= byp_hit;
        end else if (adv2) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && feed) begin
            r_s1      <= n_s1;
            r_s1_addr <= rd_addr;
            r_byp_up  <= mid_eff;
            r_byp_mid <= r_s1.bottom;
            r_rd_up   <= mem_up[rd_addr];
            r_rd_mid  <= mem_mid[rd_addr];
        end
    end

    // A read that meets a write to the same column in the same cycle takes
    // the written bits from the bypass registers.
    assign top_eff = r_byp ? r_byp_up  : r_rd_up;
    assign mid_eff = r_byp ? r_byp_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_up[r_s1_addr]  <= mid_eff;
            mem_mid[r_s1_addr] <= r_s1.bottom;
        end
    end

    // window stage: oldest column in the low bits, top row lowest
    always_comb begin
        n_win     = {r_s1.bottom, mid_eff, top_eff, r_win[8:3]};
        col_ok    = {r_s1.right_ok, 1'b1, r_s1.left_ok};
        row_ok    = {r_s1.bot_ok, 1'b1, r_s1.top_ok};
        cnt_all   = '0;
        cnt_white = '0;
        for (int p = 0; p < 3; p++) begin
            for (int q = 0; q < 3; q++) begin
                if (col_ok[p] && row_ok[q]) begin
                    cnt_all   = cnt_all + 4'd1;
                    cnt_white = cnt_white + 4'(n_win[p*3+q]);
                end
            end
        end
        if ({cnt_white, 1'b0} > {1'b0, cnt_all}) begin
            res_pixel = 1'b1;
        end else if ({cnt_white, 1'b0} < {1'b0, cnt_all}) begin
            res_pixel = 1'b0;
        end else begin
            res_pixel = n_win[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv2) begin
                r_win <= n_win;
            end
            if (adv2 && r_s1.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1.emit) begin
            r_out_pixel <= res_pixel;
            r_out_end   <= r_s1.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_frame_end = r_out_end;

`ifndef SYNTHESIS
    // Nothing owed means the lag has been reset as well.
    a_owed_implies_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owed == '0) |-> (r_fill == '0))
        else $error("owed counter empty while fill is not");

    a_owed_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed <= r_fill)
        else $error("more pixels owed than items held");

    // The result register is never overwritten while it still holds a beat.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && r_s1.emit) |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten before it was taken");

    // A write and a read to the same column meet only for one-pixel rows.
    a_bypass_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byp_hit |-> (eff_w == WB'(1)))
        else $error("line store bypass taken at a width above one");
`endif

endmodule
`default_nettype wire

### verif/binary_majority_filter_3x3_tb.sv
// ----------------------------------------------------------------------------
// binary_majority_filter_3x3_tb: self-checking bench for the 3x3 majority filter
// A table of directed beats exercises the edge ties, early and ignored flushes
// and back-to-back frames on tiny sizes. A frame as wide as the widest random
// size then fills both line stores, and random phases follow with fresh frame
// sizes, random frame content, noise flushes and partial drains. Every result
// beat is checked against a bit-accurate predictor of the filter or a table value.
// ----------------------------------------------------------------------------
module binary_majority_filter_3x3_tb;

    localparam int MAX_W          = 4096;
    localparam int PREFILL_W      = 12;
    localparam int RANDOM_BEATS   = 1850;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PLAN_LEN       = 26;

    typedef enum logic [0:0] {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } t_plan_kind;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_VALUE = 2'd2
    } t_check_kind;

    typedef struct packed {
        t_plan_kind                          kind;
        bmf3_pkg::t_opcode                   op;
        logic                                px;
        bmf3_pkg::t_cfg_index                reg_idx;
        logic [bmf3_pkg::CFG_DATA_BITS-1:0]  data;
        t_check_kind                         chk;
        logic                                e_pix;
        logic                                e_end;
    } t_plan_row;

    typedef struct packed {
        logic out_pixel;
        logic frame_end;
    } t_filtered_px;

    // Directed beats: first a 1-wide, 3-high frame, then a 3x2 frame.
    t_plan_row directed_plan [PLAN_LEN] = '{
        '{ROW_WRITE, bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd1,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_WRITE, bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_HEIGHT, 16'd3,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_NONE,  1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_VALUE, 1'b1, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_NONE,  1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_WRITE, bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'hE003,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_WRITE, bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_HEIGHT, 16'd2,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_PIXEL, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b0, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0},
        '{ROW_BEAT,  bmf3_pkg::OP_FLUSH, 1'b1, bmf3_pkg::REG_FRAME_WIDTH,  16'd0,
          CHK_MODEL, 1'b0, 1'b0}
    };

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               i_opcode    = 1'b0;
    logic                               i_in_pixel  = 1'b0;
    logic                               i_out_stall = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [0:0]                         i_cfg_index = 1'b0;
    logic [bmf3_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic                               o_out_pixel;
    logic                               o_frame_end;
    logic                               o_cfg_ready;

    binary_majority_filter_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_in_pixel (i_in_pixel),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_pixel(o_out_pixel),
        .o_frame_end(o_frame_end),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic [bmf3_pkg::FRAME_WIDTH_BITS-1:0]  width_reg  = bmf3_pkg::FRAME_WIDTH_RESET;
    logic [bmf3_pkg::FRAME_HEIGHT_BITS-1:0] height_reg = bmf3_pkg::FRAME_HEIGHT_RESET;
    bit                           store_upper  [MAX_W];
    bit                           store_middle [MAX_W];
    logic [8:0]                   window_reg = '0;
    int unsigned                  in_col   = 0;
    int unsigned                  in_row   = 0;
    int unsigned                  out_col  = 0;
    int unsigned                  out_row  = 0;
    int unsigned                  fill_cnt = 0;
    int unsigned                  owed_cnt = 0;

    t_filtered_px expected_pixels [$];
    int unsigned  mismatch_count  = 0;
    int unsigned  beats_sent      = 0;
    int unsigned  live_beats      = 0;
    int unsigned  quiet_cycles    = 0;
    int unsigned  sender_idle_pct = 20;
    int unsigned  recv_stall_pct  = 59;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    // Shifts one column into the window; flush dummies leave the stores alone.
    function automatic void feed_window(input logic bottom, input bit keep);
        int unsigned w;
        int unsigned a;
        bit          top;
        bit          mid;
        w   = active_width();
        a   = (in_col < w) ? in_col : 0;
        top = store_upper[a];
        mid = store_middle[a];
        if (keep) begin
            store_upper[a]  = mid;
            store_middle[a] = bottom;
        end
        window_reg = {bottom, mid, top, window_reg[8:3]};
        a++;
        if (a >= w) begin
            a      = 0;
            in_row = (in_row + 1 >= active_height()) ? 0 : in_row + 1;
        end
        in_col = a;
    endfunction

    // Majority over the in-frame part of the window, then advance the output position.
    function automatic t_filtered_px window_majority();
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  total;
        int unsigned  white;
        t_filtered_px res;
        w     = active_width();
        h     = active_height();
        c     = (out_col < w) ? out_col : 0;
        r     = (out_row < h) ? out_row : 0;
        total = 0;
        white = 0;
        for (int col = 0; col < 3; col++) begin
            if (col == 0 && c == 0) continue;
            if (col == 2 && c + 1 >= w) continue;
            for (int row = 0; row < 3; row++) begin
                if (row == 0 && r == 0) continue;
                if (row == 2 && r + 1 >= h) continue;
                total++;
                white += window_reg[col * 3 + row];
            end
        end
        if (2 * white > total) res.out_pixel = 1'b1;
        else if (2 * white < total) res.out_pixel = 1'b0;
        else res.out_pixel = window_reg[4];
        res.frame_end = (r + 1 >= h) && (c + 1 >= w);
        c++;
        if (c >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        out_col = c;
        out_row = r;
        return res;
    endfunction

    function automatic void majority_predict_beat(input bmf3_pkg::t_opcode op,
                                                  input logic px,
                                                  output bit produced,
                                                  output t_filtered_px res);
        int unsigned lag;
        lag      = active_width() + 1;
        produced = 1'b0;
        res      = '0;
        if (op == bmf3_pkg::OP_PIXEL) begin
            live_beats++;
            feed_window(px, 1'b1);
            fill_cnt++;
            owed_cnt++;
            if (fill_cnt > lag) begin
                res      = window_majority();
                produced = 1'b1;
                fill_cnt--;
                owed_cnt--;
            end
        end else if (owed_cnt != 0) begin
            live_beats++;
            feed_window(1'b0, 1'b0);
            fill_cnt++;
            if (fill_cnt > lag) begin
                res      = window_majority();
                produced = 1'b1;
                fill_cnt--;
                owed_cnt--;
                // Drain complete: the next pixel restarts the lag at the output position.
                if (owed_cnt == 0) begin
                    fill_cnt = 0;
                    in_col   = out_col;
                    in_row   = out_row;
                end
            end
        end
    endfunction

    task automatic send_beat(input bmf3_pkg::t_opcode op, input logic px,
                             input t_check_kind chk, input logic e_pix, input logic e_end);
        bit           produced;
        t_filtered_px res;
        // Pressure pattern rotates every 700 beats.
        case ((beats_sent / 700) % 3)
            0: begin
                sender_idle_pct = 20;
                recv_stall_pct  = 59;
            end
            1: begin
                sender_idle_pct = 59;
                recv_stall_pct  = 20;
            end
            default: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
        endcase
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_in_pixel <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        majority_predict_beat(op, px, produced, res);
        case (chk)
            CHK_MODEL: if (produced) expected_pixels.push_back(res);
            CHK_VALUE: expected_pixels.push_back('{out_pixel: e_pix, frame_end: e_end});
            default: ;
        endcase
    endtask

    // Writes happen only once every expected result is out and the pipe has settled.
    task automatic write_register(input bmf3_pkg::t_cfg_index idx,
                                  input logic [bmf3_pkg::CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == bmf3_pkg::REG_FRAME_WIDTH) begin
            width_reg = data[bmf3_pkg::FRAME_WIDTH_BITS-1:0];
        end else begin
            height_reg = data;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_filtered_px want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result beat, got out_pixel=%0b frame_end=%0b",
                         $time, o_out_pixel, o_frame_end);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_pixel !== want.out_pixel) begin
                    $display("%0t: out_pixel expected %0b, got %0b",
                             $time, want.out_pixel, o_out_pixel);
                    mismatch_count++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b, got %0b",
                             $time, want.frame_end, o_frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("binary_majority_filter_3x3_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned          base;
        int unsigned          w_eff;
        int unsigned          rows;
        int unsigned          frames;
        int unsigned          density;
        int unsigned          roll;
        logic [bmf3_pkg::CFG_DATA_BITS-1:0] w_data;
        logic [bmf3_pkg::CFG_DATA_BITS-1:0] h_data;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE) begin
                write_register(directed_plan[i].reg_idx, directed_plan[i].data);
            end else begin
                send_beat(directed_plan[i].op, directed_plan[i].px, directed_plan[i].chk,
                          directed_plan[i].e_pix, directed_plan[i].e_end);
            end
        end

        // A two-row frame as wide as the widest random size writes every line
        // store entry that the random phases can reach.
        write_register(bmf3_pkg::REG_FRAME_WIDTH, 16'(PREFILL_W));
        write_register(bmf3_pkg::REG_FRAME_HEIGHT, 16'd2);
        repeat (2 * PREFILL_W)
            send_beat(bmf3_pkg::OP_PIXEL, 1'($urandom_range(1)), CHK_MODEL, 1'b0, 1'b0);
        repeat (PREFILL_W + 1)
            send_beat(bmf3_pkg::OP_FLUSH, 1'($urandom_range(1)), CHK_MODEL, 1'b0, 1'b0);

        base = live_beats;
        while (live_beats - base < RANDOM_BEATS) begin
            roll   = $urandom_range(99);
            w_data = (roll < 6) ? 16'd0 : 16'($urandom_range(1, PREFILL_W));
            w_data = w_data | 16'($urandom_range(7) << bmf3_pkg::FRAME_WIDTH_BITS);
            roll   = $urandom_range(99);
            if (roll < 6) h_data = 16'd0;
            else if (roll < 12) h_data = 16'hFFFF;
            else h_data = 16'($urandom_range(1, 6));
            roll = $urandom_range(99);
            if (roll < 15) begin
                write_register(bmf3_pkg::REG_FRAME_WIDTH, w_data);
            end else if (roll < 30) begin
                write_register(bmf3_pkg::REG_FRAME_HEIGHT, h_data);
            end else if (roll < 65) begin
                write_register(bmf3_pkg::REG_FRAME_WIDTH, w_data);
                write_register(bmf3_pkg::REG_FRAME_HEIGHT, h_data);
            end else begin
                write_register(bmf3_pkg::REG_FRAME_HEIGHT, h_data);
                write_register(bmf3_pkg::REG_FRAME_WIDTH, w_data);
            end

            w_eff  = active_width();
            // Tall frames are cut short and left to an early flush.
            rows   = (active_height() > 8) ? $urandom_range(2, 5) : active_height();
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                density = $urandom_range(4) * 25;
                repeat (w_eff * rows) begin
                    roll = $urandom_range(199);
                    if (roll == 0) begin
                        repeat ($urandom_range(1, w_eff + 2))
                            send_beat(bmf3_pkg::OP_FLUSH, 1'($urandom_range(1)), CHK_MODEL,
                                      1'b0, 1'b0);
                    end else if (roll < 4) begin
                        send_beat(bmf3_pkg::OP_FLUSH, 1'($urandom_range(1)), CHK_MODEL,
                                  1'b0, 1'b0);
                    end
                    send_beat(bmf3_pkg::OP_PIXEL, ($urandom_range(99) < density), CHK_MODEL,
                              1'b0, 1'b0);
                end
            end

            roll = $urandom_range(99);
            if (roll < 75) begin
                repeat (w_eff + 1 + $urandom_range(2))
                    send_beat(bmf3_pkg::OP_FLUSH, 1'($urandom_range(1)), CHK_MODEL,
                              1'b0, 1'b0);
            end else if (roll < 88) begin
                repeat ($urandom_range(1, w_eff))
                    send_beat(bmf3_pkg::OP_FLUSH, 1'($urandom_range(1)), CHK_MODEL,
                              1'b0, 1'b0);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("binary_majority_filter_3x3_tb: PASS");
        end else begin
            $display("binary_majority_filter_3x3_tb: FAIL");
        end
        $finish;
    end

endmodule
